>>> sv/ecmap_pkg.sv
`default_nettype none
// ============================================================================
// Escape count color mapper package
// Shared widths, fixed-point constants, palette codes and the sine table
// builder used by the color mapper pipeline.
// ============================================================================
package ecmap_pkg;

   // Field and datapath widths.
   localparam int COUNT_BITS     = 16;
   localparam int LIMIT_BITS     = 16;
   localparam int FRACTION_BITS  = 16;
   localparam int FULL_BITS      = FRACTION_BITS + 1;
   localparam int PROD_BITS      = 2 * FRACTION_BITS;
   localparam int WIDE_PROD_BITS = 2 * FRACTION_BITS + 2;
   localparam int PHASE_BITS     = 32;
   localparam int PHASE_PROD_BITS = FRACTION_BITS + PHASE_BITS;
   localparam int PIXEL_BITS     = 24;
   localparam int CHANNEL_BITS   = 8;
   localparam int GAIN_BITS      = 12;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PALETTE_SELECT  = 1'b1;
   localparam logic [LIMIT_BITS-1:0]     LIMIT_RESET         = 16'd100;

   // Palette codes.
   typedef enum logic [1:0] {
      PALETTE_GRADIENT = 2'd0,
      PALETTE_GREY     = 2'd1,
      PALETTE_WARM     = 2'd2,
      PALETTE_SINE     = 2'd3
   } palette_type;

   // One in Q0.FRACTION_BITS, held in one extra bit.
   localparam logic [FULL_BITS-1:0] ONE_Q = FULL_BITS'(1) << FRACTION_BITS;

   // Palette gains (255 times the polynomial weights 9, 15 and 8.5 doubled).
   localparam logic [GAIN_BITS-1:0] GRAD_RED_GAIN   = 12'd2295;
   localparam logic [GAIN_BITS-1:0] GRAD_GREEN_GAIN = 12'd3825;
   localparam logic [12:0]          GRAD_BLUE_GAIN  = 13'd4335;
   localparam logic [7:0]           FULL_SCALE      = 8'd255;
   localparam logic [7:0]           WARM_RED_BASE   = 8'd204;
   localparam logic [7:0]           WARM_RED_SLOPE  = 8'd51;
   localparam logic [7:0]           WARM_GREEN_BASE = 8'd51;
   localparam logic [7:0]           WARM_GREEN_GAIN = 8'd204;
   localparam logic [7:0]           WARM_BLUE_GAIN  = 8'd50;
   localparam logic [PIXEL_BITS-1:0] PIXEL_BLACK    = 24'h000000;

   // Phase constants in Q32 turns.
   localparam logic [PHASE_BITS-1:0] TURN_NINE_TENTHS = 32'd3865470566;
   localparam logic [PHASE_BITS-1:0] PHASE_TWO_RAD    = 32'd1367130551;
   localparam logic [PHASE_BITS-1:0] PHASE_FOUR_RAD   = 32'd2734261102;

   // Sine table geometry.
   localparam int SINE_TABLE_DEPTH  = 1024;
   localparam int SINE_INDEX_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QUARTER_BITS = SINE_INDEX_BITS - 2;
   localparam int SINE_QUARTER      = SINE_TABLE_DEPTH / 4;
   localparam int SINE_FRAC_SHIFT   = 30 - SINE_QUARTER_BITS;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [SINE_QUARTER_BITS:0] sine_mag_type;

   // Control bits that travel with each item down the pipeline.
   typedef struct packed {
      logic valid;
      logic black;
   } tag_type;

   // Saturate a widened channel value to 0..255.
   function automatic logic [CHANNEL_BITS-1:0] clamp_byte(input logic [GAIN_BITS-1:0] v);
      return (v > GAIN_BITS'(FULL_SCALE)) ? FULL_SCALE : v[CHANNEL_BITS-1:0];
   endfunction

   // Channel level for a folded quarter-wave position m (in table steps).
   // The sine is a Q30 odd Taylor polynomial, clamped to 0..1; the level is
   // (sin/2 + 1/2) * 255 with the sign applied first. Used at elaboration only.
   function automatic logic [CHANNEL_BITS-1:0] sine_byte(input sine_mag_type m,
                                                         input logic negative);
      logic [63:0]        frac;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        level;
      frac = 64'(m) << SINE_FRAC_SHIFT;
      x    = (frac * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > signed'(Q30_ONE)) begin
         sum = signed'(Q30_ONE);
      end
      if (negative) begin
         sum = -sum;
      end
      level = (64'(sum + signed'(Q30_ONE)) * 64'd255) >> 31;
      return (level > 64'd255) ? 8'd255 : level[CHANNEL_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/ecmap_req_if.sv
`default_nettype none
// ============================================================================
// Escape count request channel
// Valid/ready channel that carries one escape count per transfer.
// ============================================================================
interface ecmap_req_if;
   import ecmap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] escape_count;

   modport source (output valid, output escape_count, input ready);
   modport sink   (input valid, input escape_count, output ready);
endinterface
`default_nettype wire

>>> sv/ecmap_rsp_if.sv
`default_nettype none
// ============================================================================
// Pixel color response channel
// Valid/ready channel that carries one packed RGB pixel per transfer.
// ============================================================================
interface ecmap_rsp_if;
   import ecmap_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_rgb;

   modport source (output valid, output pixel_rgb, input ready);
   modport sink   (input valid, input pixel_rgb, output ready);
endinterface
`default_nettype wire

>>> sv/ecmap_div_pipe.sv
`default_nettype none
// ============================================================================
// Pipelined fraction divider
// Forms t = floor(count * 2^FRACTION_BITS / limit) one quotient bit per
// register stage. Valid only for count < limit, which holds for every item
// that is not black.
// ============================================================================
module ecmap_div_pipe (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire ecmap_pkg::tag_type               in_tag,
   input  wire logic [ecmap_pkg::COUNT_BITS-1:0] in_count,
   input  wire logic [ecmap_pkg::LIMIT_BITS-1:0] in_limit,
   output ecmap_pkg::tag_type                    out_tag,
   output logic [ecmap_pkg::FRACTION_BITS-1:0]   out_frac
);
   import ecmap_pkg::*;

   localparam int LAST = FRACTION_BITS - 1;

   tag_type                  tag_ff [FRACTION_BITS];
   logic [LIMIT_BITS-1:0]    rem_ff [FRACTION_BITS];
   logic [LIMIT_BITS-1:0]    div_ff [FRACTION_BITS];
   logic [FRACTION_BITS-1:0] quo_ff [FRACTION_BITS];

   for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
      tag_type                  prev_tag;
      logic [LIMIT_BITS-1:0]    prev_rem;
      logic [LIMIT_BITS-1:0]    prev_div;
      logic [FRACTION_BITS-1:0] prev_quo;
      logic [LIMIT_BITS:0]      shifted;
      logic                     take;
      logic [LIMIT_BITS-1:0]    rem_in;
      logic [FRACTION_BITS-1:0] quo_in;

      // The first stage starts from the count as the partial remainder.
      if (k == 0) begin : g_first
         assign prev_tag = in_tag;
         assign prev_rem = LIMIT_BITS'(in_count);
         assign prev_div = in_limit;
         assign prev_quo = '0;
      end else begin : g_next
         assign prev_tag = tag_ff[k-1];
         assign prev_rem = rem_ff[k-1];
         assign prev_div = div_ff[k-1];
         assign prev_quo = quo_ff[k-1];
      end

      // One restoring step: double the remainder, subtract when it fits.
      always_comb begin
         shifted = {prev_rem, 1'b0};
         take    = (shifted >= {1'b0, prev_div});
         rem_in  = take ? LIMIT_BITS'(shifted - {1'b0, prev_div}) : shifted[LIMIT_BITS-1:0];
         quo_in  = {prev_quo[FRACTION_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (advance) begin
            tag_ff[k] <= prev_tag;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            div_ff[k] <= prev_div;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_tag  = tag_ff[LAST];
   assign out_frac = quo_ff[LAST];

`ifndef NO_ASSERTIONS
   // A finished quotient leaves a remainder below the divisor.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      tag_ff[LAST].valid && !tag_ff[LAST].black |-> rem_ff[LAST] < div_ff[LAST])
      else $error("divider remainder not below divisor");

   // A stall holds the last stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tag_ff[LAST]) && $stable(quo_ff[LAST]))
      else $error("divider output changed during a stall");

   // An item entering on an advance shows up in the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      advance && in_tag.valid |=> tag_ff[0].valid)
      else $error("divider lost an entering item");
`endif
endmodule
`default_nettype wire

>>> sv/ecmap_sine_lut.sv
`default_nettype none
// ============================================================================
// Sine level lookup
// Maps a phase index (one turn in SINE_TABLE_DEPTH steps) to an 8-bit
// channel level, from quarter-wave constant tables with quadrant folding.
// ============================================================================
module ecmap_sine_lut (
   input  wire logic [ecmap_pkg::SINE_INDEX_BITS-1:0] phase_index,
   output logic [ecmap_pkg::CHANNEL_BITS-1:0]         level
);
   import ecmap_pkg::*;

   localparam logic [CHANNEL_BITS-1:0] PEAK_POS = sine_byte(sine_mag_type'(SINE_QUARTER), 1'b0);
   localparam logic [CHANNEL_BITS-1:0] PEAK_NEG = sine_byte(sine_mag_type'(SINE_QUARTER), 1'b1);

   logic [CHANNEL_BITS-1:0]      pos_table [SINE_QUARTER];
   logic [CHANNEL_BITS-1:0]      neg_table [SINE_QUARTER];
   logic [SINE_QUARTER_BITS-1:0] step;
   logic [SINE_QUARTER_BITS-1:0] mirror;
   logic [SINE_QUARTER_BITS-1:0] fold;
   logic                         odd_quadrant;
   logic                         negative;
   logic                         peak;

   // Quarter-wave levels for the upper and lower half of the wave.
   for (genvar k = 0; k < SINE_QUARTER; k++) begin : g_table
      localparam logic [CHANNEL_BITS-1:0] POS = sine_byte(sine_mag_type'(k), 1'b0);
      localparam logic [CHANNEL_BITS-1:0] NEG = sine_byte(sine_mag_type'(k), 1'b1);
      assign pos_table[k] = POS;
      assign neg_table[k] = NEG;
   end

   // Fold odd quadrants back; the crest of the wave sits one past the table.
   always_comb begin
      step         = phase_index[SINE_QUARTER_BITS-1:0];
      odd_quadrant = phase_index[SINE_QUARTER_BITS];
      negative     = phase_index[SINE_QUARTER_BITS+1];
      mirror       = ~step + 1'b1;
      fold         = odd_quadrant ? mirror : step;
      peak         = odd_quadrant && (step == '0);
      if (peak) begin
         level = negative ? PEAK_NEG : PEAK_POS;
      end else begin
         level = negative ? neg_table[fold] : pos_table[fold];
      end
   end
endmodule
`default_nettype wire

>>> sv/escape_count_color_mapper.sv
`default_nettype none
// ============================================================================
// Escape count color mapper
// Turns one fractal escape count per pixel into a packed 24-bit RGB color.
// ============================================================================
// Takes one escape count per clock and returns one pixel per clock unless
// the result channel stalls, in order, through one input stage, one stage
// per bit of the 16-bit pipelined divider that forms t = count/limit, three
// palette multiply stages and the output register. Counts at or above
// iteration_limit give black. Every stage holds on a stall of the result
// channel, and req_chan.ready is low only while a finished pixel waits and
// rsp_chan.ready is low. Write iteration_limit (index 0) and palette_select
// (index 1) only while no pixel is in flight; they reset to 100 and the
// polynomial gradient. Red is in bits 23:16, green 15:8, blue 7:0.
module escape_count_color_mapper (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ecmap_req_if.sink                                 req_chan,
   ecmap_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [ecmap_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ecmap_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import ecmap_pkg::*;

   localparam int F = FRACTION_BITS;

   logic                   advance;
   logic [LIMIT_BITS-1:0]  iteration_limit_ff;
   palette_type            palette_ff;

   tag_type                s0_tag_ff, s0_tag_in;
   logic [COUNT_BITS-1:0]  s0_count_ff;

   tag_type                d_tag;
   logic [F-1:0]           d_frac;

   // Stage 1 products.
   tag_type                s1_tag_ff;
   logic [F-1:0]           s1_t_ff, s1_t_in;
   logic [F:0]             s1_u_ff, s1_u_in;
   logic [F-1:0]           s1_t2_ff, s1_t2_in;
   logic [F:0]             s1_u2_ff, s1_u2_in;
   logic [PHASE_BITS-1:0]  s1_phase_ff, s1_phase_in;
   logic [7:0]             s1_grey_ff, s1_grey_in;
   logic [7:0]             s1_warm_r_ff, s1_warm_r_in;
   logic [7:0]             s1_warm_b_ff, s1_warm_b_in;
   logic [PROD_BITS-1:0]   tt_prod, grey_prod, warm_r_prod;
   logic [WIDE_PROD_BITS-1:0] uu_prod, warm_b_prod;
   logic [PHASE_PROD_BITS-1:0] phase_prod;

   // Stage 2 products.
   tag_type                s2_tag_ff;
   logic [F-1:0]           s2_t_ff;
   logic [F:0]             s2_u_ff;
   logic [F-1:0]           s2_t3_ff, s2_t3_in;
   logic [F-1:0]           s2_g0_ff, s2_g0_in;
   logic [F:0]             s2_u3_ff, s2_u3_in;
   logic [7:0]             s2_warm_g_ff, s2_warm_g_in;
   logic [SINE_INDEX_BITS-1:0] s2_idx_r_ff, s2_idx_r_in;
   logic [SINE_INDEX_BITS-1:0] s2_idx_g_ff, s2_idx_g_in;
   logic [SINE_INDEX_BITS-1:0] s2_idx_b_ff, s2_idx_b_in;
   logic [7:0]             s2_grey_ff, s2_warm_r_ff, s2_warm_b_ff;
   logic [PROD_BITS-1:0]   t3_prod, warm_g_prod;
   logic [WIDE_PROD_BITS-1:0] g0_prod, u3_prod;
   logic [PHASE_BITS-1:0]  phase_g, phase_b;

   // Stage 3 products.
   tag_type                s3_tag_ff;
   logic [F-1:0]           s3_r1_ff, s3_r1_in;
   logic [F-1:0]           s3_b1_ff, s3_b1_in;
   logic [7:0]             s3_grad_g_ff, s3_grad_g_in;
   logic [7:0]             s3_sine_r_ff, s3_sine_g_ff, s3_sine_b_ff;
   logic [7:0]             sine_r, sine_g, sine_b;
   logic [7:0]             s3_grey_ff, s3_warm_r_ff, s3_warm_g_ff, s3_warm_b_ff;
   logic [WIDE_PROD_BITS-1:0] r1_prod, b1_prod;
   logic [PROD_BITS-1:0]   grad_g_prod;

   // Output register.
   logic                   rsp_valid_ff;
   logic [PIXEL_BITS-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic [PROD_BITS-1:0]   grad_r_prod, grad_b_prod;
   logic [7:0]             grad_r, grad_b;

   // The whole pipeline moves unless a finished pixel is stuck at the output.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_rgb = rsp_pixel_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         iteration_limit_ff <= LIMIT_RESET;
         palette_ff         <= PALETTE_GRADIENT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ITERATION_LIMIT: iteration_limit_ff <= csr_write_data[LIMIT_BITS-1:0];
            CSR_PALETTE_SELECT:  palette_ff <= palette_type'(csr_write_data[1:0]);
            default: ;
         endcase
      end
   end

   // Input stage: capture the count and flag counts at or above the limit.
   always_comb begin
      s0_tag_in.valid = req_chan.valid;
      s0_tag_in.black = (LIMIT_BITS'(req_chan.escape_count) >= iteration_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
      end else if (advance) begin
         s0_tag_ff <= s0_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_count_ff <= req_chan.escape_count;
      end
   end

   ecmap_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (s0_tag_ff),
      .in_count (s0_count_ff),
      .in_limit (iteration_limit_ff),
      .out_tag  (d_tag),
      .out_frac (d_frac)
   );

   // Stage 1: squares, sine phase and the single-multiply palettes.
   always_comb begin
      s1_t_in      = d_frac;
      s1_u_in      = ONE_Q - FULL_BITS'(d_frac);
      tt_prod      = PROD_BITS'(d_frac) * PROD_BITS'(d_frac);
      uu_prod      = WIDE_PROD_BITS'(s1_u_in) * WIDE_PROD_BITS'(s1_u_in);
      phase_prod   = PHASE_PROD_BITS'(d_frac) * PHASE_PROD_BITS'(TURN_NINE_TENTHS);
      grey_prod    = PROD_BITS'(d_frac) * PROD_BITS'(FULL_SCALE);
      warm_r_prod  = PROD_BITS'(d_frac) * PROD_BITS'(WARM_RED_SLOPE);
      warm_b_prod  = WIDE_PROD_BITS'(s1_u_in) * WIDE_PROD_BITS'(WARM_BLUE_GAIN);
      s1_t2_in     = tt_prod[PROD_BITS-1:F];
      s1_u2_in     = uu_prod[2*F:F];
      s1_phase_in  = phase_prod[F+PHASE_BITS-1:F];
      s1_grey_in   = grey_prod[F+7:F];
      s1_warm_r_in = WARM_RED_BASE + warm_r_prod[F+7:F];
      s1_warm_b_in = warm_b_prod[F+7:F];
   end

   // Stage 2: cubes and mixed terms, warm green level, sine table addresses.
   always_comb begin
      t3_prod      = PROD_BITS'(s1_t2_ff) * PROD_BITS'(s1_t_ff);
      g0_prod      = WIDE_PROD_BITS'(s1_u2_ff) * WIDE_PROD_BITS'(s1_t2_ff);
      u3_prod      = WIDE_PROD_BITS'(s1_u2_ff) * WIDE_PROD_BITS'(s1_u_ff);
      warm_g_prod  = PROD_BITS'(s1_t2_ff) * PROD_BITS'(WARM_GREEN_GAIN);
      phase_g      = s1_phase_ff + PHASE_TWO_RAD;
      phase_b      = s1_phase_ff + PHASE_FOUR_RAD;
      s2_t3_in     = t3_prod[PROD_BITS-1:F];
      s2_g0_in     = g0_prod[2*F-1:F];
      s2_u3_in     = u3_prod[2*F:F];
      s2_warm_g_in = WARM_GREEN_BASE + warm_g_prod[F+7:F];
      s2_idx_r_in  = s1_phase_ff[PHASE_BITS-1 -: SINE_INDEX_BITS];
      s2_idx_g_in  = phase_g[PHASE_BITS-1 -: SINE_INDEX_BITS];
      s2_idx_b_in  = phase_b[PHASE_BITS-1 -: SINE_INDEX_BITS];
   end

   ecmap_sine_lut u_sine_r (.phase_index(s2_idx_r_ff), .level(sine_r));
   ecmap_sine_lut u_sine_g (.phase_index(s2_idx_g_ff), .level(sine_g));
   ecmap_sine_lut u_sine_b (.phase_index(s2_idx_b_ff), .level(sine_b));

   // Stage 3: last gradient terms, green gradient channel, sine levels.
   always_comb begin
      r1_prod      = WIDE_PROD_BITS'(s2_u_ff) * WIDE_PROD_BITS'(s2_t3_ff);
      b1_prod      = WIDE_PROD_BITS'(s2_u3_ff) * WIDE_PROD_BITS'(s2_t_ff);
      grad_g_prod  = PROD_BITS'(s2_g0_ff) * PROD_BITS'(GRAD_GREEN_GAIN);
      s3_r1_in     = r1_prod[2*F-1:F];
      s3_b1_in     = b1_prod[2*F-1:F];
      s3_grad_g_in = clamp_byte(grad_g_prod[F+GAIN_BITS-1:F]);
   end

   // Output stage: red and blue gradient channels and the palette choice.
   always_comb begin
      grad_r_prod = PROD_BITS'(s3_r1_ff) * PROD_BITS'(GRAD_RED_GAIN);
      grad_b_prod = PROD_BITS'(s3_b1_ff) * PROD_BITS'(GRAD_BLUE_GAIN);
      grad_r      = clamp_byte(grad_r_prod[F+GAIN_BITS-1:F]);
      grad_b      = clamp_byte(grad_b_prod[F+GAIN_BITS:F+1]);
      case (palette_ff)
         PALETTE_GRADIENT: rsp_pixel_in = {grad_r, s3_grad_g_ff, grad_b};
         PALETTE_GREY:     rsp_pixel_in = {s3_grey_ff, s3_grey_ff, s3_grey_ff};
         PALETTE_WARM:     rsp_pixel_in = {s3_warm_r_ff, s3_warm_g_ff, s3_warm_b_ff};
         PALETTE_SINE:     rsp_pixel_in = {s3_sine_r_ff, s3_sine_g_ff, s3_sine_b_ff};
         default:          rsp_pixel_in = PIXEL_BLACK;
      endcase
      if (s3_tag_ff.black) begin
         rsp_pixel_in = PIXEL_BLACK;
      end
   end

   // Valid bits of the palette stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff    <= '0;
         s2_tag_ff    <= '0;
         s3_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_tag_ff    <= d_tag;
         s2_tag_ff    <= s1_tag_ff;
         s3_tag_ff    <= s2_tag_ff;
         rsp_valid_ff <= s3_tag_ff.valid;
      end
   end

   // Payload of the palette stages and the output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff      <= s1_t_in;
         s1_u_ff      <= s1_u_in;
         s1_t2_ff     <= s1_t2_in;
         s1_u2_ff     <= s1_u2_in;
         s1_phase_ff  <= s1_phase_in;
         s1_grey_ff   <= s1_grey_in;
         s1_warm_r_ff <= s1_warm_r_in;
         s1_warm_b_ff <= s1_warm_b_in;

         s2_t_ff      <= s1_t_ff;
         s2_u_ff      <= s1_u_ff;
         s2_t3_ff     <= s2_t3_in;
         s2_g0_ff     <= s2_g0_in;
         s2_u3_ff     <= s2_u3_in;
         s2_warm_g_ff <= s2_warm_g_in;
         s2_idx_r_ff  <= s2_idx_r_in;
         s2_idx_g_ff  <= s2_idx_g_in;
         s2_idx_b_ff  <= s2_idx_b_in;
         s2_grey_ff   <= s1_grey_ff;
         s2_warm_r_ff <= s1_warm_r_ff;
         s2_warm_b_ff <= s1_warm_b_ff;

         s3_r1_ff     <= s3_r1_in;
         s3_b1_ff     <= s3_b1_in;
         s3_grad_g_ff <= s3_grad_g_in;
         s3_sine_r_ff <= sine_r;
         s3_sine_g_ff <= sine_g;
         s3_sine_b_ff <= sine_b;
         s3_grey_ff   <= s2_grey_ff;
         s3_warm_r_ff <= s2_warm_r_ff;
         s3_warm_g_ff <= s2_warm_g_ff;
         s3_warm_b_ff <= s2_warm_b_ff;

         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A black item leaves the pipeline as a black pixel.
   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      advance && s3_tag_ff.valid && s3_tag_ff.black |=> rsp_valid_ff && rsp_pixel_ff == PIXEL_BLACK)
      else $error("count at or above the limit did not give black");

   // A stall freezes the last palette stage and the output register.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s3_tag_ff) && $stable(rsp_valid_ff) && $stable(rsp_pixel_ff))
      else $error("pipeline moved during a stall");

   // A new pixel appears only when the stage before held an item.
   a_pixel_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_tag_ff.valid))
      else $error("pixel appeared without an item behind it");
`endif
endmodule
`default_nettype wire
